/* hw/rtl/multinomial_inverse_cdf_sampler_top_defines.svh */
// Assertion helpers for the sampler block
`ifndef MULTINOMIAL_INVERSE_CDF_SAMPLER_TOP_DEFINES_SVH
`define MULTINOMIAL_INVERSE_CDF_SAMPLER_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define MICS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sampler check failed");

// next-cycle implication
`define MICS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sampler check failed");

`endif

/* hw/rtl/mics_pkg.sv */
package mics_pkg;

	localparam int MAX_BINS_DEF      = 64;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int CMD_W             = 2;
	localparam int PROP_W            = 16;
	localparam int COUNT_W           = 16;
	localparam int BIN_IDX_W         = 6;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD = 2'd0,
		CMD_DRAW = 2'd1,
		CMD_EMIT = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	// broadcast controls for the whole row of cells
	typedef struct packed {
		logic shift;
		logic clear;
	} chain_ctl_t;

endpackage

/* hw/rtl/multinomial_inverse_cdf_sampler_top.sv */
// Load, draw and no-op words are taken one per cycle while in_ready is high and give no output word.
// A draw walks the row of bin cells, one cell per cycle.
// Emit waits until no draw is left in the row, then sends one word per cycle while out_ready
// is high for each loaded bin, shifting counts toward cell 0; no input is taken meanwhile.
// Reset (arst_n low, asynchronous) clears counts, bin count, running sum and draws in flight;
// no clearing pass follows reset.
`include "multinomial_inverse_cdf_sampler_top_defines.svh"

module multinomial_inverse_cdf_sampler_top import mics_pkg::*; #(
	parameter int MAX_BINS      = MAX_BINS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CMD_W-1:0]     cmd,
	input  logic [PROP_W-1:0]    proportion,
	input  logic [PROP_W-1:0]    uniform,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BIN_IDX_W-1:0] bin_index,
	output logic [COUNT_W-1:0]   bin_count,
	output logic                 last
);

	localparam int TW  = FRACTION_BITS + 6;
	localparam int NBW = $clog2(MAX_BINS + 1);
	localparam logic [TW-1:0] FMASK = TW'((64'd1 << FRACTION_BITS) - 64'd1);

	typedef enum logic [1:0] {
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t         state_q;
	logic [NBW-1:0] nb_q;
	logic [TW-1:0]  sum_q;
	logic [NBW-1:0] idx_q;

	logic           in_acc;
	logic           full;
	logic           load_go;
	logic           draw_go;
	logic           busy;
	logic           last_w;
	logic [TW:0]    sum_ext;
	logic [TW-1:0]  sum_nxt;
	logic [TW-1:0]  u_m;
	chain_ctl_t     ctl;

	logic [MAX_BINS:0]              tok_v_c;
	logic [MAX_BINS:0][TW-1:0]      tok_u_c;
	logic [MAX_BINS:0][NBW-1:0]     tok_n_c;
	logic [MAX_BINS-1:0]            busy_c;
	logic [MAX_BINS-1:0]            load_en_c;
	logic [MAX_BINS-1:0][COUNT_W-1:0] cnt_c;

	assign in_ready  = (state_q == ST_RUN);
	assign in_acc    = in_valid && in_ready;
	assign full      = (nb_q == NBW'(MAX_BINS));
	assign load_go   = in_acc && (cmd_t'(cmd) == CMD_LOAD) && !full;
	assign draw_go   = in_acc && (cmd_t'(cmd) == CMD_DRAW);
	assign busy      = |busy_c;
	assign last_w    = (NBW'(idx_q + 1'b1) == nb_q);

	// saturating running sum
	assign sum_ext = {1'b0, sum_q} + {1'b0, TW'(proportion) & FMASK};
	assign sum_nxt = sum_ext[TW] ? '1 : sum_ext[TW-1:0];
	assign u_m     = TW'(uniform) & FMASK;

	assign ctl.shift = (state_q == ST_EMIT) && out_ready;
	assign ctl.clear = ((state_q == ST_DRAIN) && !busy && (nb_q == '0))
		|| ((state_q == ST_EMIT) && out_ready && last_w);

	assign tok_v_c[0] = draw_go;
	assign tok_u_c[0] = u_m;
	assign tok_n_c[0] = nb_q;

	for (genvar i = 0; i < MAX_BINS; i++) begin : g_cell
		logic [COUNT_W-1:0] cnt_in;

		assign load_en_c[i] = load_go && (nb_q == NBW'(i));

		if (i == MAX_BINS - 1) begin : g_tail
			assign cnt_in = '0;
		end else begin : g_link
			assign cnt_in = cnt_c[i+1];
		end

		mics_cell #(
			.IDX (i),
			.TW  (TW),
			.NBW (NBW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.load_en   (load_en_c[i]),
			.load_thr  (sum_nxt),
			.tok_v_in  (tok_v_c[i]),
			.tok_u_in  (tok_u_c[i]),
			.tok_n_in  (tok_n_c[i]),
			.tok_v_out (tok_v_c[i+1]),
			.tok_u_out (tok_u_c[i+1]),
			.tok_n_out (tok_n_c[i+1]),
			.busy      (busy_c[i]),
			.count_in  (cnt_in),
			.count     (cnt_c[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			nb_q    <= '0;
			sum_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (load_go) begin
						nb_q  <= nb_q + 1'b1;
						sum_q <= sum_nxt;
					end else if (in_acc && (cmd_t'(cmd) == CMD_EMIT)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!busy) begin
						idx_q <= '0;
						if (nb_q == '0) begin
							state_q <= ST_RUN;
							sum_q   <= '0;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						if (last_w) begin
							state_q <= ST_RUN;
							nb_q    <= '0;
							sum_q   <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	assign out_valid = (state_q == ST_EMIT);
	assign bin_index = BIN_IDX_W'(idx_q);
	assign bin_count = cnt_c[0];
	assign last      = last_w;

	`MICS_ASSERT_NOW(a_in_out_excl, in_ready, !out_valid)
	`MICS_ASSERT_NOW(a_emit_has_bins, out_valid, nb_q != '0)
	`MICS_ASSERT_NEXT(a_last_clears, out_valid && out_ready && last, nb_q == '0 && in_ready)

endmodule

/* hw/rtl/mics_cell.sv */
module mics_cell import mics_pkg::*; #(
	parameter int IDX = 0,
	parameter int TW  = 22,
	parameter int NBW = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  chain_ctl_t         ctl,
	input  logic               load_en,
	input  logic [TW-1:0]      load_thr,
	input  logic               tok_v_in,
	input  logic [TW-1:0]      tok_u_in,
	input  logic [NBW-1:0]     tok_n_in,
	output logic               tok_v_out,
	output logic [TW-1:0]      tok_u_out,
	output logic [NBW-1:0]     tok_n_out,
	output logic               busy,
	input  logic [COUNT_W-1:0] count_in,
	output logic [COUNT_W-1:0] count
);

	logic [TW-1:0]      thr_q;
	logic [COUNT_W-1:0] count_q;
	logic               tok_v_q;
	logic [TW-1:0]      tok_u_q;
	logic [NBW-1:0]     tok_n_q;
	logic               hit;

	// a draw only sees bins that were loaded when it entered the row
	assign hit = tok_v_q && (NBW'(IDX) < tok_n_q) && (thr_q >= tok_u_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tok_v_q <= 1'b0;
		end else begin
			tok_v_q <= tok_v_in;
			if (ctl.clear) begin
				count_q <= '0;
			end else if (ctl.shift) begin
				count_q <= count_in;
			end else if (hit && count_q != '1) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_u_q <= tok_u_in;
		tok_n_q <= tok_n_in;
		if (load_en) begin
			thr_q <= load_thr;
		end
	end

	assign tok_v_out = tok_v_q && !hit;
	assign tok_u_out = tok_u_q;
	assign tok_n_out = tok_n_q;
	assign busy      = tok_v_q;
	assign count     = count_q;

endmodule
